FILE: rtl/dkim_body_canonicalizer_top_defines.svh
// assertion macros for the dkim body canonicalizer
`ifndef DKIM_BODY_CANONICALIZER_TOP_DEFINES_SVH
`define DKIM_BODY_CANONICALIZER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define DKIMBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define DKIMBC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DKIMBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)

`define DKIMBC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/dkimbc_pkg.sv
// shared types and constants of the dkim body canonicalizer
`timescale 1ns / 1ps

package dkimbc_pkg;

    localparam int PENDING_WIDTH_DEF = 16;
    localparam int PAIRS_W           = 16;
    localparam int BYTE_W            = 8;
    localparam int OUT_PAD_W         = 4;

    localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_SP  = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_TAB = 8'h09;

    typedef struct packed {
        logic [BYTE_W-1:0] body_byte;
        logic              byte_present;
        logic              end_of_body;
    } item_t;

    typedef struct packed {
        logic [PAIRS_W-1:0] crlf_pairs;
        logic               space_first;
        logic               cr_first;
        logic [BYTE_W-1:0]  out_byte;
        logic               out_valid;
        logic               crlf_after;
        logic               overflow;
        logic               last;
    } token_t;

endpackage

FILE: rtl/dkimbc_pipe_reg.sv
// one-deep pipeline register with valid/ready handshake
`timescale 1ns / 1ps

module dkimbc_pipe_reg #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    // refill in the same cycle the held word leaves
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

FILE: rtl/dkimbc_step.sv
// stream state and per-byte canonicalization logic
`timescale 1ns / 1ps

module dkimbc_step #(
    parameter int PENDING_WIDTH = dkimbc_pkg::PENDING_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               relaxed,
    input  logic               fire,
    input  dkimbc_pkg::item_t  item,
    output dkimbc_pkg::token_t token
);

    import dkimbc_pkg::*;

    // count never exceeds the 16-bit pairs field
    localparam int CNT_W = (PENDING_WIDTH > PAIRS_W) ? PAIRS_W : PENDING_WIDTH;

    logic [CNT_W-1:0] pending_reg, pending_next;
    logic             ws_reg, ws_next;
    logic             hc_reg, hc_next;
    logic             lhc_reg, lhc_next;
    logic             ae_reg, ae_next;
    logic             ovf_reg, ovf_next;

    logic is_lf, is_data, is_cr, is_wsp, emit_byte, hc_after, end_cr;
    logic prefix, count, sat, lhc_mid, ae_mid, ovf_mid;

    always_comb
    begin
        is_lf     = item.byte_present && (item.body_byte == CHAR_LF);
        is_data   = item.byte_present && !is_lf;
        is_cr     = (item.body_byte == CHAR_CR);
        is_wsp    = (item.body_byte == CHAR_SP) || (item.body_byte == CHAR_TAB);
        emit_byte = is_data && !is_cr && !(relaxed && is_wsp);
        hc_after  = is_lf ? 1'b0 : (is_data ? is_cr : hc_reg);
        // a cr still held at end of body goes out as plain data
        end_cr    = item.end_of_body && hc_after;
        prefix    = (is_data && hc_reg) || emit_byte || end_cr;
        count     = is_lf && !(relaxed && lhc_reg);
        sat       = &pending_reg;
        lhc_mid   = is_lf ? 1'b0 : (prefix ? 1'b1 : lhc_reg);
        ae_mid    = ae_reg || prefix;
        ovf_mid   = ovf_reg || (count && sat);

        token.crlf_pairs  = prefix ? PAIRS_W'(pending_reg) : '0;
        token.space_first = prefix && relaxed && ws_reg;
        token.cr_first    = is_data && hc_reg;
        token.out_byte    = emit_byte ? item.body_byte : (end_cr ? CHAR_CR : '0);
        token.out_valid   = emit_byte || end_cr;
        token.crlf_after  = (is_lf && relaxed && lhc_reg)
                          || (item.end_of_body && (!relaxed || lhc_mid || !ae_mid));
        token.overflow    = ovf_mid;
        token.last        = item.end_of_body;

        if (item.end_of_body)
        begin
            pending_next = '0;
            ws_next      = 1'b0;
            hc_next      = 1'b0;
            lhc_next     = 1'b0;
            ae_next      = 1'b0;
            ovf_next     = 1'b0;
        end
        else
        begin
            if (prefix)
            begin
                pending_next = '0;
            end
            else if (count && !sat)
            begin
                pending_next = pending_reg + CNT_W'(1);
            end
            else
            begin
                pending_next = pending_reg;
            end
            if (is_lf)
            begin
                ws_next = 1'b0;
            end
            else if (is_data && relaxed && is_wsp)
            begin
                ws_next = 1'b1;
            end
            else if (prefix)
            begin
                ws_next = 1'b0;
            end
            else
            begin
                ws_next = ws_reg;
            end
            hc_next  = hc_after;
            lhc_next = lhc_mid;
            ae_next  = ae_mid;
            ovf_next = ovf_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            ws_reg      <= 1'b0;
            hc_reg      <= 1'b0;
            lhc_reg     <= 1'b0;
            ae_reg      <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else if (fire)
        begin
            pending_reg <= pending_next;
            ws_reg      <= ws_next;
            hc_reg      <= hc_next;
            lhc_reg     <= lhc_next;
            ae_reg      <= ae_next;
            ovf_reg     <= ovf_next;
        end
    end

endmodule

FILE: rtl/dkim_body_canonicalizer_top.sv
// DKIM body canonicalizer, simple and relaxed, one body byte per word.
// A word taken sits in the input register. The step logic turns it into its token, which
// is loaded into the result register when that register can take it. Both registers
// refill in the cycle they drain, so a new word is accepted on every cycle while the
// output side is ready. A stalled output holds the input back once both registers are full.
// The user is to write relaxed_mode over the cfg channel between bodies; the block itself
// does not enforce this. It applies to each word that the step logic takes after the write.
`timescale 1ns / 1ps
`include "dkim_body_canonicalizer_top_defines.svh"

module dkim_body_canonicalizer_top #(
    parameter int PENDING_WIDTH = dkimbc_pkg::PENDING_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data,       // relaxed_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // body_byte
    input  logic [0:0]  s_axis_tuser,   // byte_present
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // crlf_pairs, space_first, cr_first,
                                        // out_byte, crlf_after, overflow, pad
    output logic [0:0]  m_axis_tuser,   // out_valid
    output logic        m_axis_tlast
);

    import dkimbc_pkg::*;

    logic   relaxed_reg;
    item_t  in_item, step_item;
    token_t step_token, out_token;
    logic   step_valid, step_ready, step_fire;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relaxed_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            relaxed_reg <= cfg_data[0];
        end
    end

    assign in_item.body_byte    = s_axis_tdata;
    assign in_item.byte_present = s_axis_tuser[0];
    assign in_item.end_of_body  = s_axis_tlast;

    dkimbc_pipe_reg #(
        .WIDTH ($bits(item_t))
    ) u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (in_item),
        .out_valid (step_valid),
        .out_ready (step_ready),
        .out_data  (step_item)
    );

    assign step_fire = step_valid && step_ready;

    dkimbc_step #(
        .PENDING_WIDTH (PENDING_WIDTH)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .relaxed (relaxed_reg),
        .fire    (step_fire),
        .item    (step_item),
        .token   (step_token)
    );

    dkimbc_pipe_reg #(
        .WIDTH ($bits(token_t))
    ) u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (step_valid),
        .in_ready  (step_ready),
        .in_data   (step_token),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_token)
    );

    assign m_axis_tdata = {OUT_PAD_W'(0), out_token.overflow, out_token.crlf_after,
                           out_token.out_byte, out_token.cr_first,
                           out_token.space_first, out_token.crlf_pairs};
    assign m_axis_tuser = out_token.out_valid;
    assign m_axis_tlast = out_token.last;

    // deferred pairs are only flushed ahead of real content
    `DKIMBC_ASSERT_IMP(a_pairs_need_content, clk, rst_n,
        m_axis_tvalid && (out_token.crlf_pairs != '0),
        out_token.out_valid || out_token.cr_first, "crlf pairs without content")

    // collapsed whitespace only exists in relaxed mode
    `DKIMBC_ASSERT_IMP(a_space_relaxed, clk, rst_n,
        m_axis_tvalid && out_token.space_first,
        relaxed_reg && (out_token.out_valid || out_token.cr_first),
        "space token outside relaxed content")

    // end of body leaves a clean stream state
    `DKIMBC_ASSERT_NXT(a_eob_clears, clk, rst_n,
        step_fire && step_item.end_of_body,
        (step_token.crlf_pairs == '0) && !step_token.overflow,
        "stream state not cleared after end of body")

endmodule

FILE: tb/tb_dkim_body_canonicalizer_top.sv
// testbench of the dkim body canonicalizer: directed bodies, line count saturation, random bodies
`timescale 1ns / 1ps

module tb_dkim_body_canonicalizer_top;
    import dkimbc_pkg::*;

    localparam int          PEND_W        = PENDING_WIDTH_DEF;
    localparam int unsigned PEND_MAX      = (PEND_W >= 16) ? 32'hFFFF : ((32'd1 << PEND_W) - 1);
    localparam int          IDLE_PCT      = 27;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          RANDOM_WORDS  = 700;
    localparam int          PRINT_CAP     = 100;
    localparam int unsigned SAT_RUN_CAP   = 60;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_data      = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // body_byte
    logic [0:0]  s_axis_tuser  = 1'b0;    // byte_present
    logic        s_axis_tlast  = 1'b0;    // end_of_body
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;            // crlf_pairs, space_first, cr_first, out_byte,
                                          // crlf_after, overflow, zero pad
    logic [0:0]  m_axis_tuser;            // out_valid
    logic        m_axis_tlast;            // last

    // predictor state
    logic        relaxed;
    int unsigned lines_pend;
    logic        ws_run;
    logic        cr_held;
    logic        line_content;
    logic        body_emitted;
    logic        sat_seen;

    token_t      want_tokens[$];
    int          mismatches    = 0;
    int          words_sent    = 0;
    int          stall_cycles  = 0;
    bit          src_calm      = 1'b0;
    bit          snk_calm      = 1'b0;

    dkim_body_canonicalizer_top #(
        .PENDING_WIDTH(PEND_W)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // flush deferred line breaks and the collapsed space ahead of content
    task automatic emit_prefix(inout token_t t);
        t.crlf_pairs = t.crlf_pairs + lines_pend[15:0];
        lines_pend   = 0;
        if (relaxed && ws_run)
            t.space_first = 1'b1;
        ws_run       = 1'b0;
        line_content = 1'b1;
        body_emitted = 1'b1;
    endtask

    task automatic canonicalize_word(input item_t w, output token_t t);
        logic ws;
        t  = '0;
        ws = (w.body_byte == CHAR_SP) || (w.body_byte == CHAR_TAB);
        if (w.byte_present)
        begin
            if (w.body_byte == CHAR_LF)
            begin
                cr_held = 1'b0;
                if (relaxed && line_content)
                    t.crlf_after = 1'b1;
                else if (lines_pend >= PEND_MAX)
                    sat_seen = 1'b1;
                else
                    lines_pend++;
                line_content = 1'b0;
                ws_run       = 1'b0;
            end
            else
            begin
                // a held cr not followed by lf is plain data
                if (cr_held)
                begin
                    emit_prefix(t);
                    t.cr_first = 1'b1;
                    cr_held    = 1'b0;
                end
                if (w.body_byte == CHAR_CR)
                    cr_held = 1'b1;
                else if (relaxed && ws)
                    ws_run = 1'b1;
                else
                begin
                    emit_prefix(t);
                    t.out_byte  = w.body_byte;
                    t.out_valid = 1'b1;
                end
            end
        end
        if (w.end_of_body)
        begin
            if (cr_held)
            begin
                emit_prefix(t);
                t.out_byte  = CHAR_CR;
                t.out_valid = 1'b1;
                cr_held     = 1'b0;
            end
            if (!relaxed || line_content || !body_emitted)
                t.crlf_after = 1'b1;
            t.last = 1'b1;
        end
        t.overflow = sat_seen;
        if (w.end_of_body)
        begin
            lines_pend   = 0;
            ws_run       = 1'b0;
            cr_held      = 1'b0;
            line_content = 1'b0;
            body_emitted = 1'b0;
            sat_seen     = 1'b0;
        end
    endtask

    task automatic push_word(input logic [7:0] b, input logic present, input logic eob);
        item_t  w;
        token_t t;
        while (!src_calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= present;
        s_axis_tlast  <= eob;
        do
            @(posedge clk);
        while (!s_axis_tready);
        w.body_byte    = b;
        w.byte_present = present;
        w.end_of_body  = eob;
        canonicalize_word(w, t);
        want_tokens = {want_tokens, t};
        if (present || eob)
            words_sent++;
    endtask

    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (want_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_relaxed(input logic v);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        relaxed = v;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 8'h61 + 8'($urandom_range(0, 25));
        else if (r < 52)
            return CHAR_SP;
        else if (r < 60)
            return CHAR_TAB;
        else if (r < 72)
            return CHAR_LF;
        else if (r < 82)
            return CHAR_CR;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_simple_directed();
        set_relaxed(1'b0);
        push_word(8'h61, 1'b1, 1'b0);
        push_word(CHAR_CR, 1'b1, 1'b0);
        push_word(CHAR_LF, 1'b1, 1'b0);
        push_word(CHAR_LF, 1'b1, 1'b0);
        push_word(CHAR_CR, 1'b1, 1'b0);     // lone cr, then data
        push_word(8'h62, 1'b1, 1'b0);
        push_word(CHAR_CR, 1'b1, 1'b1);     // cr held at end of body
        push_word(8'h5A, 1'b0, 1'b1);       // empty body
        push_word(8'hFF, 1'b1, 1'b0);
        push_word(8'hA5, 1'b0, 1'b0);       // idle word
        push_word(8'h00, 1'b1, 1'b1);
    endtask

    task automatic test_relaxed_directed();
        set_relaxed(1'b1);
        push_word(CHAR_SP, 1'b1, 1'b0);
        push_word(CHAR_TAB, 1'b1, 1'b0);
        push_word(8'h78, 1'b1, 1'b0);
        push_word(CHAR_SP, 1'b1, 1'b0);
        push_word(CHAR_TAB, 1'b1, 1'b0);
        push_word(CHAR_CR, 1'b1, 1'b0);
        push_word(CHAR_LF, 1'b1, 1'b0);
        push_word(CHAR_SP, 1'b1, 1'b0);     // whitespace only line counts as blank
        push_word(CHAR_LF, 1'b1, 1'b0);
        push_word(8'h79, 1'b1, 1'b0);
        push_word(CHAR_LF, 1'b1, 1'b0);
        push_word(CHAR_LF, 1'b1, 1'b1);
        push_word(8'h00, 1'b0, 1'b1);       // empty body
        push_word(CHAR_SP, 1'b1, 1'b0);
        push_word(CHAR_TAB, 1'b1, 1'b1);
    endtask

    task automatic test_line_saturation();
        int unsigned lf_run;
        // the counter only saturates within a short run when it is narrow
        lf_run = (PEND_MAX + 3 <= SAT_RUN_CAP) ? PEND_MAX + 3 : SAT_RUN_CAP;
        set_relaxed(1'b0);
        push_word(8'h7A, 1'b1, 1'b0);
        for (int i = 0; i < lf_run; i++)
            push_word(CHAR_LF, 1'b1, 1'b0);
        push_word(8'h71, 1'b1, 1'b0);
        push_word(CHAR_LF, 1'b1, 1'b0);
        push_word(8'h00, 1'b0, 1'b1);
        // flag must be gone in the next body
        push_word(8'h6B, 1'b1, 1'b1);
    endtask

    task automatic test_random_bodies();
        int         len;
        logic [7:0] c;
        while (words_sent < RANDOM_WORDS)
        begin
            src_calm = (words_sent >= 300) && (words_sent < 420);
            snk_calm = src_calm;
            if ($urandom_range(0, 9) < 3)
                set_relaxed(1'($urandom_range(0, 1)));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 20);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 199) == 0)
                    set_relaxed(1'($urandom_range(0, 1)));     // switch inside a body
                if ($urandom_range(0, 99) < 3)
                    push_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                else
                begin
                    c = pick_char();
                    push_word(c, 1'b1, 1'b0);
                    if (c == CHAR_CR && $urandom_range(0, 9) < 7)
                        push_word(CHAR_LF, 1'b1, 1'b0);
                end
            end
            if ($urandom_range(0, 1))
                push_word(pick_char(), 1'b1, 1'b1);
            else
                push_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
        src_calm = 1'b0;
        snk_calm = 1'b0;
    endtask

    always @(posedge clk)
        m_axis_tready <= snk_calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin : check_tokens
        token_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (want_tokens.size() == 0)
                flag_mismatch("token with nothing expected");
            else
            begin
                want = want_tokens.pop_front();
                if (m_axis_tdata[15:0] !== want.crlf_pairs)
                    flag_mismatch($sformatf("crlf_pairs %0d, want %0d",
                                            m_axis_tdata[15:0], want.crlf_pairs));
                if (m_axis_tdata[16] !== want.space_first)
                    flag_mismatch($sformatf("space_first %b, want %b",
                                            m_axis_tdata[16], want.space_first));
                if (m_axis_tdata[17] !== want.cr_first)
                    flag_mismatch($sformatf("cr_first %b, want %b",
                                            m_axis_tdata[17], want.cr_first));
                if (m_axis_tdata[25:18] !== want.out_byte)
                    flag_mismatch($sformatf("out_byte %h, want %h",
                                            m_axis_tdata[25:18], want.out_byte));
                if (m_axis_tdata[26] !== want.crlf_after)
                    flag_mismatch($sformatf("crlf_after %b, want %b",
                                            m_axis_tdata[26], want.crlf_after));
                if (m_axis_tdata[27] !== want.overflow)
                    flag_mismatch($sformatf("overflow %b, want %b",
                                            m_axis_tdata[27], want.overflow));
                if (m_axis_tdata[31:28] !== 4'h0)
                    flag_mismatch($sformatf("pad bits %h", m_axis_tdata[31:28]));
                if (m_axis_tuser[0] !== want.out_valid)
                    flag_mismatch($sformatf("out_valid %b, want %b",
                                            m_axis_tuser[0], want.out_valid));
                if (m_axis_tlast !== want.last)
                    flag_mismatch($sformatf("last %b, want %b", m_axis_tlast, want.last));
            end
        end
    end

    // ends the run when nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        relaxed      = 1'b0;
        lines_pend   = 0;
        ws_run       = 1'b0;
        cr_held      = 1'b0;
        line_content = 1'b0;
        body_emitted = 1'b0;
        sat_seen     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_simple_directed();
        test_relaxed_directed();
        test_line_saturation();
        test_random_bodies();

        settle_block();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (want_tokens.size() != 0)
            flag_mismatch($sformatf("%0d tokens never arrived", want_tokens.size()));
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
